// ===== sv/uls_pkg.sv =====
// Upload link sequencer package: phase codes, sleep constants, register
// indexes, register reset values and the transaction and register structs.
// No dependencies.
package uls_pkg;

  // Sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADV  = 2'd1,
    PH_SEND = 2'd2,
    PH_ACK  = 2'd3
  } phase_t;

  // Register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_RETRY_INTERVAL    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ADVERTISE_TIMEOUT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ACK_TIMEOUT       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PACKET_GAP        = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DAY_GAP           = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_IDLE_SLEEP        = 3'd5;

  // Register reset values
  localparam logic [31:0] RST_RETRY_INTERVAL    = 32'd60000;
  localparam logic [31:0] RST_ADVERTISE_TIMEOUT = 32'd30000;
  localparam logic [31:0] RST_ACK_TIMEOUT       = 32'd5000;
  localparam logic [15:0] RST_PACKET_GAP        = 16'd20;
  localparam logic [15:0] RST_DAY_GAP           = 16'd200;
  localparam logic [15:0] RST_IDLE_SLEEP        = 16'd60000;

  // Sleep times reported outside idle
  localparam logic [15:0] SLEEP_ADV  = 16'd30;
  localparam logic [15:0] SLEEP_BUSY = 16'd10;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        pending_data;
    logic        central_connected;
    logic        subscribed;
    logic        ack_received;
    logic        packets_finished;
  } tick_t;

  typedef struct packed {
    logic        radio_poll;
    logic        radio_on;
    logic        radio_off;
    logic        send_header;
    logic        send_packet;
    logic        clear_day;
    logic [1:0]  phase;
    logic [15:0] sleep_ms;
  } cmd_t;

  typedef struct packed {
    logic [31:0] retry_interval_ms;
    logic [31:0] advertise_timeout_ms;
    logic [31:0] ack_timeout_ms;
    logic [15:0] packet_gap_ms;
    logic [15:0] day_gap_ms;
    logic [15:0] idle_sleep_ms;
  } cfg_t;

endpackage

// ===== sv/uls_cfg_regs.sv =====
// Upload link sequencer configuration registers.
// Depends on uls_pkg.
module uls_cfg_regs
  import uls_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_wdata,
  output cfg_t               cfg
);

  // Write one register; drop bits above its width, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_interval_ms    <= RST_RETRY_INTERVAL;
      cfg.advertise_timeout_ms <= RST_ADVERTISE_TIMEOUT;
      cfg.ack_timeout_ms       <= RST_ACK_TIMEOUT;
      cfg.packet_gap_ms        <= RST_PACKET_GAP;
      cfg.day_gap_ms           <= RST_DAY_GAP;
      cfg.idle_sleep_ms        <= RST_IDLE_SLEEP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RETRY_INTERVAL:    cfg.retry_interval_ms    <= cfg_wdata;
        REG_ADVERTISE_TIMEOUT: cfg.advertise_timeout_ms <= cfg_wdata;
        REG_ACK_TIMEOUT:       cfg.ack_timeout_ms       <= cfg_wdata;
        REG_PACKET_GAP:        cfg.packet_gap_ms        <= cfg_wdata[15:0];
        REG_DAY_GAP:           cfg.day_gap_ms           <= cfg_wdata[15:0];
        REG_IDLE_SLEEP:        cfg.idle_sleep_ms        <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/uls_step.sv =====
// Upload link sequencer step: phase machine state and the combinational
// logic that turns one tick into one command transaction.
// Depends on uls_pkg.
module uls_step
  import uls_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step_en,
  input  tick_t tick,
  input  cfg_t  cfg,
  output cmd_t  cmd
);

  phase_t      cur_phase, cur_phase_next;
  logic        header_done, header_done_next;
  logic [31:0] last_packet_at, last_packet_at_next;
  logic [31:0] last_failure_at, last_failure_at_next;
  logic        fail_valid, fail_valid_next;
  logic [31:0] phase_start_at, phase_start_at_next;
  logic [31:0] pause_start_at, pause_start_at_next;
  logic        pausing, pausing_next;

  logic retry_due, adv_expired, gap_due, ack_expired, day_gap_due;

  // Wrapped time differences against the thresholds
  assign retry_due   = (tick.now_ms - last_failure_at) >= cfg.retry_interval_ms;
  assign adv_expired = (tick.now_ms - phase_start_at) >= cfg.advertise_timeout_ms;
  assign gap_due     = (tick.now_ms - last_packet_at) >= {16'd0, cfg.packet_gap_ms};
  assign ack_expired = (tick.now_ms - phase_start_at) >= cfg.ack_timeout_ms;
  assign day_gap_due = (tick.now_ms - pause_start_at) >= {16'd0, cfg.day_gap_ms};

  // Step the phase machine once for this tick
  always_comb begin
    cur_phase_next       = cur_phase;
    header_done_next     = header_done;
    last_packet_at_next  = last_packet_at;
    last_failure_at_next = last_failure_at;
    fail_valid_next      = fail_valid;
    phase_start_at_next  = phase_start_at;
    pause_start_at_next  = pause_start_at;
    pausing_next         = pausing;
    cmd                  = '0;
    cmd.radio_poll       = (cur_phase != PH_IDLE);

    case (cur_phase)
      PH_IDLE: begin
        if (tick.pending_data && (!fail_valid || retry_due)) begin
          cmd.radio_on        = 1'b1;
          phase_start_at_next = tick.now_ms;
          cur_phase_next      = PH_ADV;
        end
      end
      PH_ADV: begin
        if (tick.central_connected && tick.subscribed) begin
          header_done_next     = 1'b0;
          fail_valid_next      = 1'b0;
          last_failure_at_next = '0;
          cur_phase_next       = PH_SEND;
        end else if (adv_expired) begin
          last_failure_at_next = tick.now_ms;
          fail_valid_next      = 1'b1;
          cmd.radio_off        = 1'b1;
          cur_phase_next       = PH_IDLE;
        end
      end
      PH_SEND: begin
        if (!tick.central_connected) begin
          last_failure_at_next = tick.now_ms;
          fail_valid_next      = 1'b1;
          cmd.radio_off        = 1'b1;
          cur_phase_next       = PH_IDLE;
        end else if (!header_done) begin
          cmd.send_header     = 1'b1;
          header_done_next    = 1'b1;
          last_packet_at_next = tick.now_ms;
        end else if (gap_due) begin
          cmd.send_packet     = 1'b1;
          last_packet_at_next = tick.now_ms;
          if (tick.packets_finished) begin
            phase_start_at_next = tick.now_ms;
            cur_phase_next      = PH_ACK;
          end
        end
      end
      PH_ACK: begin
        if (pausing) begin
          // Hold off the next day until the gap has run out
          if (day_gap_due) begin
            pausing_next        = 1'b0;
            header_done_next    = 1'b0;
            phase_start_at_next = tick.now_ms;
            cur_phase_next      = PH_SEND;
          end
        end else if (!tick.central_connected || ack_expired) begin
          last_failure_at_next = tick.now_ms;
          fail_valid_next      = 1'b1;
          cmd.radio_off        = 1'b1;
          cur_phase_next       = PH_IDLE;
        end else if (tick.ack_received) begin
          cmd.clear_day = 1'b1;
          if (tick.pending_data) begin
            pausing_next        = 1'b1;
            pause_start_at_next = tick.now_ms;
          end else begin
            cmd.radio_off  = 1'b1;
            cur_phase_next = PH_IDLE;
          end
        end
      end
      default: ;
    endcase

    cmd.phase = cur_phase_next;
    case (cur_phase_next)
      PH_IDLE: cmd.sleep_ms = cfg.idle_sleep_ms;
      PH_ADV:  cmd.sleep_ms = SLEEP_ADV;
      default: cmd.sleep_ms = SLEEP_BUSY;
    endcase
  end

  // Advance state only when the tick is committed to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_phase       <= PH_IDLE;
      header_done     <= 1'b0;
      last_packet_at  <= '0;
      last_failure_at <= '0;
      fail_valid      <= 1'b0;
      phase_start_at  <= '0;
      pause_start_at  <= '0;
      pausing         <= 1'b0;
    end else if (step_en) begin
      cur_phase       <= cur_phase_next;
      header_done     <= header_done_next;
      last_packet_at  <= last_packet_at_next;
      last_failure_at <= last_failure_at_next;
      fail_valid      <= fail_valid_next;
      phase_start_at  <= phase_start_at_next;
      pause_start_at  <= pause_start_at_next;
      pausing         <= pausing_next;
    end
  end

endmodule

// ===== sv/upload_link_sequencer.sv =====
// Upload link sequencer top level: input register, step logic, output register.
// Depends on uls_pkg, uls_cfg_regs and uls_step.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   tick     | tick_valid / tick_stall| tick (time and link flags)
//   cmd      | cmd_valid / cmd_stall  | cmd (commands, phase, sleep)
//   config   | cfg_we                 | cfg_index, cfg_wdata
//
// One tick per clock sustained while cmd is not stalled; a taken tick goes
// through the input register, then the step logic into the output register.
// Phase state advances in the same edge that loads the output register.
// A stall on cmd holds the output register and backs up into tick_stall.
// Reset is synchronous: phase idle, all timestamps zero, registers default.
module upload_link_sequencer
  import uls_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_stall,
  input  tick_t              tick,
  output logic               cmd_valid,
  input  logic               cmd_stall,
  output cmd_t               cmd,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_wdata
);

  cfg_t  cfg;
  tick_t tick_q;
  logic  tick_q_valid;
  cmd_t  step_cmd;
  logic  fire;

  uls_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Step a held tick whenever the output register is free or draining
  assign fire       = tick_q_valid && (!cmd_valid || !cmd_stall);
  assign tick_stall = tick_q_valid && !fire;

  uls_step u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (fire),
    .tick    (tick_q),
    .cfg     (cfg),
    .cmd     (step_cmd)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q_valid <= 1'b0;
    end else if (!tick_stall) begin
      tick_q_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) begin
      tick_q <= tick;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= fire || (cmd_valid && cmd_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cmd <= step_cmd;
    end
  end

endmodule

// ===== sv/uls_checker.sv =====
// Upload link sequencer port checker and its bind to the top level.
// Depends on uls_pkg and upload_link_sequencer.
module uls_checker
  import uls_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  cmd_valid,
  input logic  cmd_stall,
  input cmd_t  cmd
);

  // Hold a stalled command transaction
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
    else $error("stalled command transaction changed");

  // Radio on only when entering advertising
  a_on_adv: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd.radio_on |-> cmd.phase == PH_ADV && !cmd.radio_poll)
    else $error("radio on outside entry to advertising");

  // Radio off only when dropping to idle from an active phase
  a_off_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd.radio_off |-> cmd.phase == PH_IDLE && cmd.radio_poll)
    else $error("radio off without return to idle");

  // Sleep time follows the phase outside idle
  a_sleep: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd.phase != PH_IDLE |->
      (cmd.phase == PH_ADV && cmd.sleep_ms == SLEEP_ADV) ||
      (cmd.phase != PH_ADV && cmd.sleep_ms == SLEEP_BUSY))
    else $error("sleep time does not match phase");

  // Header and packet never go out together, nor with a radio switch
  a_one_send: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> $countones({cmd.radio_on, cmd.radio_off,
                              cmd.send_header, cmd.send_packet}) <= 1)
    else $error("conflicting commands in one transaction");

endmodule

bind upload_link_sequencer uls_checker u_uls_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd_valid),
  .cmd_stall  (cmd_stall),
  .cmd        (cmd)
);
